### rtl/mpc_pkg.sv
// Package for the MED predictive pixel coder: sizes, register indexes, MED predictor.
package mpc_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WIDTH_W    = 13;
  localparam int EW         = (COL_W + 1 > WIDTH_W) ? COL_W + 1 : WIDTH_W;
  localparam int PIX_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam logic [CFG_IDX_W-1:0] REG_CODER_MODE  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = CFG_IDX_W'(1);

  localparam logic MODE_ENCODE = 1'b0;
  localparam logic MODE_DECODE = 1'b1;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef logic [COL_W-1:0] col_t;
  typedef logic [EW-1:0]    ewidth_t;

  function automatic pixel_t med_predict(input pixel_t a, input pixel_t b, input pixel_t c);
    pixel_t lo;
    pixel_t hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    if (c >= hi) begin
      return lo;
    end else if (c <= lo) begin
      return hi;
    end else begin
      return pixel_t'(a + b - c);
    end
  endfunction

endpackage

### rtl/mpc_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port with enable.
module mpc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/med_predictive_pixel_coder_top.sv
// Top level of the MED predictive pixel coder: row tracking, line buffer, predictor, output register.
// An accepted word passes through the p1 registers and then the output register to the master side.
// Throughput: one word per cycle while m_tready does not hold the output; the line buffer read is issued at accept
// and its data is used in the p1 stage, with a bypass when the word ahead writes the same column.
// Reset clears row position, neighbor registers and handshake state, and loads encode
// mode with a width of 640. The line buffer is not cleared.
module med_predictive_pixel_coder_top (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  mpc_pkg::pixel_t                   s_tdata,   // [7:0] sample_in
  input  logic                              s_tuser,   // [0] frame_start
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output mpc_pkg::pixel_t                   m_tdata,   // [7:0] sample_out
  input  logic                              cfg_we,
  input  logic [mpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [mpc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);
  import mpc_pkg::*;

  logic                 coder_mode;
  logic [WIDTH_W-1:0]   image_width;

  col_t    column_count;
  logic    past_first_row;
  pixel_t  left_pixel;
  pixel_t  upper_left_pixel;

  logic    p1_valid;
  col_t    p1_col;
  logic    p1_past;
  pixel_t  p1_sample;
  logic    p1_fwd;
  pixel_t  p1_fwd_data;

  ewidth_t effw;
  ewidth_t w_ext;
  logic    accept;
  logic    p1_adv;
  col_t    cnt_a;
  logic    past_a;
  col_t    col;
  logic    past;
  col_t    column_count_next;
  logic    past_first_row_next;

  pixel_t  rdata;
  pixel_t  above;
  pixel_t  pred;
  pixel_t  pixel;
  pixel_t  result;

  function automatic pixel_t s_add(input pixel_t x, input pixel_t y);
    return pixel_t'(x + y);
  endfunction

  always_comb begin
    w_ext = EW'(image_width);
    if (w_ext == '0) begin
      effw = EW'(1);
    end else if (w_ext > EW'(MAX_WIDTH)) begin
      effw = EW'(MAX_WIDTH);
    end else begin
      effw = w_ext;
    end
  end

  assign p1_adv   = p1_valid && (!m_tvalid || m_tready);
  assign s_tready = !p1_valid || p1_adv;
  assign accept   = s_tvalid && s_tready;

  // row position of the incoming word
  always_comb begin
    cnt_a  = s_tuser ? '0 : column_count;
    past_a = s_tuser ? 1'b0 : past_first_row;
    if (EW'(cnt_a) >= effw) begin
      col  = '0;
      past = 1'b1;
    end else begin
      col  = cnt_a;
      past = past_a;
    end
    if (EW'(col) + EW'(1) >= effw) begin
      column_count_next   = '0;
      past_first_row_next = 1'b1;
    end else begin
      column_count_next   = col + COL_W'(1);
      past_first_row_next = past;
    end
  end

  // predictor and coder
  always_comb begin
    above = p1_past ? (p1_fwd ? p1_fwd_data : rdata) : '0;
    if (p1_past && (p1_col != '0)) begin
      pred = med_predict(left_pixel, above, upper_left_pixel);
    end else begin
      pred = '0;
    end
    if (coder_mode == MODE_DECODE) begin
      pixel  = s_add(p1_sample, pred);
      result = pixel;
    end else begin
      pixel  = p1_sample;
      result = pixel_t'(p1_sample - pred);
    end
  end

  mpc_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_line_buf (
    .clk   (clk),
    .we    (p1_adv),
    .waddr (p1_col),
    .wdata (pixel),
    .re    (accept),
    .raddr (col),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      coder_mode  <= MODE_ENCODE;
      image_width <= WIDTH_W'(640);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CODER_MODE:  coder_mode  <= cfg_wdata[0];
        REG_IMAGE_WIDTH: image_width <= cfg_wdata[WIDTH_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count     <= '0;
      past_first_row   <= 1'b0;
      p1_valid         <= 1'b0;
      left_pixel       <= '0;
      upper_left_pixel <= '0;
      m_tvalid         <= 1'b0;
    end else begin
      if (accept) begin
        column_count   <= column_count_next;
        past_first_row <= past_first_row_next;
        p1_valid       <= 1'b1;
      end else if (p1_adv) begin
        p1_valid <= 1'b0;
      end
      if (p1_adv) begin
        left_pixel       <= pixel;
        upper_left_pixel <= above;
        m_tvalid         <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_col      <= col;
      p1_past     <= past;
      p1_sample   <= s_tdata;
      // the word ahead writes this column in the same cycle as our read
      p1_fwd      <= p1_adv && (p1_col == col);
      p1_fwd_data <= pixel;
    end
    if (p1_adv) begin
      m_tdata <= result;
    end
  end

endmodule
